### rtl/core/svnp_pkg.sv
// ----------------------------------------------------------------------------
// svnp_pkg
// Shared widths, register indexes and types for the sphere vertex placer.
// ----------------------------------------------------------------------------
package svnp_pkg;

  localparam int unsigned VW  = 16;   // vertex coordinate width, Q2.14
  localparam int unsigned RW  = 12;   // config register width
  localparam int unsigned OW  = 18;   // placed coordinate width, 4 frac bits
  localparam int unsigned QW  = 16;   // radial magnitude width (0..16*radius)
  localparam int unsigned SW  = 32;   // sum of squares width
  localparam int unsigned BW  = 64;   // (2*R*|v|)^2 width
  localparam int unsigned PW  = 51;   // signed (2q-1)*S width
  localparam int unsigned AW  = 70;   // signed accumulator width for (2q-1)^2*S
  localparam int unsigned NCH = 3;    // coordinates per vertex

  typedef enum logic [1:0] {
    REG_RADIUS   = 2'd0,
    REG_CENTER_X = 2'd1,
    REG_CENTER_Y = 2'd2,
    REG_CENTER_Z = 2'd3
  } reg_idx_t;

endpackage

### rtl/core/sphere_vertex_normalize_place.sv
// ----------------------------------------------------------------------------
// sphere_vertex_normalize_place
// Puts a Q2.14 vertex on a sphere of configured radius and centre.
// ----------------------------------------------------------------------------
// Takes one vertex word per cycle while the output side is not stalled and
// returns one placed point per vertex. A 16-step digit-by-digit search
// finds round(R*|v|/|vec|): one pipeline stage per result bit, built from
// shifts and adds only, after two stages that form the squares, the sum of
// squares and the bound. A stall on the output holds the whole pipeline.
// Zero-length vertices give all zeros with zero_vector set. The user is to
// write registers only while the pipe is empty; the block does not check.
module sphere_vertex_normalize_place (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // vertex_x, vertex_y, vertex_z
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // placed_x, placed_y, placed_z, zero pad
  output logic        out_tuser,  // zero_vector
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [11:0] cfg_wdata
);

  localparam int unsigned VW = svnp_pkg::VW;
  localparam int unsigned QW = svnp_pkg::QW;
  localparam int unsigned SW = svnp_pkg::SW;
  localparam int unsigned BW = svnp_pkg::BW;
  localparam int unsigned PW = svnp_pkg::PW;
  localparam int unsigned AW = svnp_pkg::AW;
  localparam int unsigned OW = svnp_pkg::OW;
  localparam int unsigned NC = svnp_pkg::NCH;

  // config
  logic [svnp_pkg::RW-1:0] radius_r, cx_r, cy_r, cz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= 12'd400;
      cx_r     <= 12'd500;
      cy_r     <= 12'd500;
      cz_r     <= 12'd0;
    end else if (cfg_we) begin
      unique case (svnp_pkg::reg_idx_t'(cfg_addr))
        svnp_pkg::REG_RADIUS:   radius_r <= cfg_wdata;
        svnp_pkg::REG_CENTER_X: cx_r     <= cfg_wdata;
        svnp_pkg::REG_CENTER_Y: cy_r     <= cfg_wdata;
        svnp_pkg::REG_CENTER_Z: cz_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic en;
  logic v1_r, v2_r, v3_r;
  logic [QW:0] vs_r;   // search stage valid bits, index 0 feeds stage 0
  logic vo_r;

  assign en        = !vo_r || out_tready;
  assign in_tready = en;

  // stage 1: input register
  logic signed [VW-1:0] vin_r [NC];

  // stage 2: squares, magnitudes, 2*R*|v|
  logic [SW-1:0] sq_r  [NC];
  logic [31:0]   p_r   [NC];
  logic          sg2_r [NC];

  // stage 3 feeds the search (index 0 of the arrays below)
  logic [SW-1:0] s_r   [QW+1];
  logic [BW-1:0] b_r   [QW+1][NC];
  logic          sg_r  [QW+1][NC];
  logic [QW-1:0] q_r   [QW+1][NC];
  logic signed [PW-1:0] pp_r [QW+1][NC];
  logic signed [AW-1:0] aa_r [QW+1][NC];
  logic          zr_r  [QW+1];

  logic [QW-1:0] r16;
  assign r16 = {radius_r, 4'b0000};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_tvalid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < NC; c++) begin
        vin_r[c] <= in_tdata[c*VW +: VW];
      end
    end
  end

  always_ff @(posedge clk) begin
    logic [VW-1:0] av;
    if (en) begin
      for (int c = 0; c < NC; c++) begin
        av = vin_r[c][VW-1] ? VW'(-vin_r[c]) : VW'(vin_r[c]);
        sq_r[c]  <= SW'(av) * SW'(av);
        p_r[c]   <= 32'({r16, 1'b0}) * 32'(av);
        sg2_r[c] <= vin_r[c][VW-1];
      end
    end
  end

  // stage 3: S, bound, search seed with q = 0: P = -S, Q = S
  always_ff @(posedge clk) begin
    logic [SW-1:0] s;
    if (en) begin
      s = sq_r[0] + sq_r[1] + sq_r[2];
      s_r[0]  <= s;
      zr_r[0] <= (s == '0);
      for (int c = 0; c < NC; c++) begin
        b_r[0][c]  <= BW'(p_r[c]) * BW'(p_r[c]);
        sg_r[0][c] <= sg2_r[c];
        q_r[0][c]  <= '0;
        pp_r[0][c] <= -$signed({{(PW-SW){1'b0}}, s});
        aa_r[0][c] <= $signed({{(AW-SW){1'b0}}, s});
      end
    end
  end

  assign vs_r[0] = v3_r;

  // search: stage j decides bit i = QW-1-j of q
  for (genvar j = 0; j < QW; j++) begin : g_srch
    localparam int unsigned I = QW - 1 - j;

    logic vld_r;
    assign vs_r[j+1] = vld_r;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r <= 1'b0;
      end else if (en) begin
        vld_r <= vs_r[j];
      end
    end

    always_ff @(posedge clk) begin
      logic signed [AW-1:0] s_w, qc;
      if (en) begin
        s_w = $signed({{(AW-SW){1'b0}}, s_r[j]});
        s_r[j+1]  <= s_r[j];
        zr_r[j+1] <= zr_r[j];
        for (int c = 0; c < NC; c++) begin
          qc = aa_r[j][c] + (AW'(pp_r[j][c]) <<< (I + 2)) + (s_w <<< (2*I + 2));
          b_r[j+1][c]  <= b_r[j][c];
          sg_r[j+1][c] <= sg_r[j][c];
          if (qc <= $signed({{(AW-BW){1'b0}}, b_r[j][c]})) begin
            q_r[j+1][c]  <= q_r[j][c] | (QW'(1) << I);
            aa_r[j+1][c] <= qc;
            pp_r[j+1][c] <= pp_r[j][c] + (PW'(s_w) <<< (I + 1));
          end else begin
            q_r[j+1][c]  <= q_r[j][c];
            aa_r[j+1][c] <= aa_r[j][c];
            pp_r[j+1][c] <= pp_r[j][c];
          end
        end
      end
    end
  end

  // output stage: add centre
  logic [OW-1:0] pl_r [NC];
  logic          zo_r;
  logic [OW-1:0] ctr  [NC];

  assign ctr[0] = {2'b00, cx_r, 4'b0000};
  assign ctr[1] = {2'b00, cy_r, 4'b0000};
  assign ctr[2] = {{2{cz_r[11]}}, cz_r, 4'b0000};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else if (en) begin
      vo_r <= vs_r[QW];
    end
  end

  always_ff @(posedge clk) begin
    logic [OW-1:0] rq;
    if (en) begin
      zo_r <= zr_r[QW];
      for (int c = 0; c < NC; c++) begin
        rq = {2'b00, q_r[QW][c]};
        if (zr_r[QW]) begin
          pl_r[c] <= '0;
        end else begin
          pl_r[c] <= ctr[c] + (sg_r[QW][c] ? OW'(-rq) : rq);
        end
      end
    end
  end

  assign out_tvalid = vo_r;
  assign out_tdata  = {2'b00, pl_r[2], pl_r[1], pl_r[0]};
  assign out_tuser  = zo_r;

endmodule

### verif/tb_sphere_vertex_normalize_place.sv
// ----------------------------------------------------------------------------
// tb_sphere_vertex_normalize_place
// Self-checking bench for the sphere vertex placer: a predictor computes the
// rounded radial parts by exact integer search, and a scoreboard compares
// each placed point against the oldest prediction under random idling.
// ----------------------------------------------------------------------------
module tb_sphere_vertex_normalize_place;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [15:0] vz;
    logic signed [15:0] vy;
    logic signed [15:0] vx;
  } vertex_t;

  typedef struct {
    logic [17:0] px;
    logic [17:0] py;
    logic [17:0] pz;
    logic        zero;
  } point_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;
  logic        out_tuser;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = svnp_pkg::REG_RADIUS;
  logic [11:0] cfg_wdata = '0;

  sphere_vertex_normalize_place dut (.*);

  // shadow registers
  logic [11:0]        radius_q = 12'd400;
  logic [11:0]        cx_q = 12'd500;
  logic [11:0]        cy_q = 12'd500;
  logic signed [11:0] cz_q = 12'sd0;

  vertex_t vertex_q[$];
  point_t  placed_q[$];
  int      errors = 0;

  // handshakes seen at the last rising edge
  bit      in_taken = 0;
  bit      out_taken = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // round(r16*av/sqrt(s)), ties away from zero
  function automatic logic [15:0] radial_mag(logic [15:0] r16, logic [15:0] av,
                                             logic [31:0] s);
    logic [63:0]  p;
    logic [127:0] b, k, lhs;
    logic [16:0]  lo, hi, mid;
    p = 64'(2) * r16 * av;
    b = 128'(p) * p;
    lo = '0;
    hi = 17'(r16);
    while (lo < hi) begin
      mid = lo + ((hi - lo + 17'd1) >> 1);
      k = 128'(2) * mid - 128'(1);
      lhs = k * k * s;
      if (lhs <= b) lo = mid;
      else hi = mid - 17'd1;
    end
    return lo[15:0];
  endfunction

  function automatic logic [17:0] place_coord(int c, logic signed [15:0] v,
                                              logic [15:0] r16, logic [31:0] s);
    int q, av;
    av = (v < 0) ? -int'(v) : int'(v);
    q = int'(radial_mag(r16, 16'(av), s));
    return 18'(c * 16 + ((v < 0) ? -q : q));
  endfunction

  function automatic point_t predict_point(vertex_t vt);
    point_t      pt;
    logic [31:0] s;
    logic [15:0] r16;
    s = 32'(int'(vt.vx) * int'(vt.vx)) + 32'(int'(vt.vy) * int'(vt.vy))
      + 32'(int'(vt.vz) * int'(vt.vz));
    r16 = {radius_q, 4'd0};
    if (s == 0) begin
      pt.px = '0; pt.py = '0; pt.pz = '0; pt.zero = 1'b1;
    end else begin
      pt.px = place_coord(int'(cx_q), vt.vx, r16, s);
      pt.py = place_coord(int'(cy_q), vt.vy, r16, s);
      pt.pz = place_coord(int'(cz_q), vt.vz, r16, s);
      pt.zero = 1'b0;
    end
    return pt;
  endfunction

  always @(posedge clk) begin
    in_taken = rst_n && in_tvalid && in_tready;
    out_taken = rst_n && out_tvalid && out_tready;
  end

  // driver
  int send_gap = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_taken) begin
        void'(vertex_q.pop_front());
        send_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 7);
      end
      if (send_gap > 0) begin
        send_gap--;
        in_tvalid <= 1'b0;
      end else if (vertex_q.size() > 0) begin
        in_tvalid <= 1'b1;
        in_tdata <= vertex_q[0];
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // output stall
  int stall = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_taken)
        stall = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // monitor: predict on acceptance, compare on result
  always @(posedge clk) begin
    point_t got, want;
    if (rst_n) begin
      if (in_tvalid && in_tready)
        placed_q = {placed_q, predict_point(vertex_t'(in_tdata))};
      if (out_tvalid && out_tready) begin
        got.px = out_tdata[17:0];
        got.py = out_tdata[35:18];
        got.pz = out_tdata[53:36];
        got.zero = out_tuser;
        if (placed_q.size() == 0) begin
          $display("%0t: unexpected word px=%h py=%h pz=%h zero=%b", $time,
                   got.px, got.py, got.pz, got.zero);
          errors++;
        end else begin
          want = placed_q.pop_front();
          if (got.px !== want.px) begin
            $display("%0t: placed_x expected %h actual %h", $time, want.px, got.px);
            errors++;
          end
          if (got.py !== want.py) begin
            $display("%0t: placed_y expected %h actual %h", $time, want.py, got.py);
            errors++;
          end
          if (got.pz !== want.pz) begin
            $display("%0t: placed_z expected %h actual %h", $time, want.pz, got.pz);
            errors++;
          end
          if (got.zero !== want.zero) begin
            $display("%0t: zero_vector expected %b actual %b", $time, want.zero,
                     got.zero);
            errors++;
          end
        end
      end
    end
  end

  task automatic write_reg(svnp_pkg::reg_idx_t idx, logic [11:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      svnp_pkg::REG_RADIUS:   radius_q = val;
      svnp_pkg::REG_CENTER_X: cx_q = val;
      svnp_pkg::REG_CENTER_Y: cy_q = val;
      svnp_pkg::REG_CENTER_Z: cz_q = val;
    endcase
  endtask

  task automatic drain();
    while (vertex_q.size() > 0 || placed_q.size() > 0) @(posedge clk);
    repeat (25) @(posedge clk);
  endtask

  task automatic add_vertex(int x, int y, int z);
    vertex_t vt;
    vt.vx = 16'(x); vt.vy = 16'(y); vt.vz = 16'(z);
    vertex_q = {vertex_q, vt};
  endtask

  function automatic int rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 7) - 4;
      1: return $urandom_range(0, 1) ? 32767 : -32768;
      2: return $urandom_range(0, 511) - 256;
      default: return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: reset settings, extremes, zero vector, axes, ties
    add_vertex(0, 0, 0);
    add_vertex(16384, 0, 0);
    add_vertex(0, -16384, 0);
    add_vertex(0, 0, 32767);
    add_vertex(-32768, -32768, -32768);
    add_vertex(32767, 32767, 32767);
    add_vertex(-32768, 32767, 0);
    add_vertex(1, 0, 0);
    add_vertex(0, 0, -1);
    add_vertex(1, 1, 1);
    add_vertex(-1, 2, -2);
    add_vertex(3, 4, 0);
    add_vertex(0, 0, 0);
    drain();

    // extremes of the registers
    write_reg(svnp_pkg::REG_RADIUS, 12'd4095);
    write_reg(svnp_pkg::REG_CENTER_X, 12'd0);
    write_reg(svnp_pkg::REG_CENTER_Y, 12'd4095);
    write_reg(svnp_pkg::REG_CENTER_Z, 12'h800);
    add_vertex(-32768, 0, 0);
    add_vertex(0, 32767, 0);
    add_vertex(0, 0, -32768);
    add_vertex(1, -1, 1);
    add_vertex(0, 0, 0);
    drain();
    write_reg(svnp_pkg::REG_RADIUS, 12'd0);
    write_reg(svnp_pkg::REG_CENTER_X, 12'd4095);
    write_reg(svnp_pkg::REG_CENTER_Y, 12'd0);
    write_reg(svnp_pkg::REG_CENTER_Z, 12'h7ff);
    add_vertex(32767, -32768, 5);
    add_vertex(0, 0, 1);
    drain();

    // random phases with random settings, last one at extremes
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 7) begin
        write_reg(svnp_pkg::REG_RADIUS, 12'd4095);
        write_reg(svnp_pkg::REG_CENTER_X, 12'd4095);
        write_reg(svnp_pkg::REG_CENTER_Y, 12'd4095);
        write_reg(svnp_pkg::REG_CENTER_Z, 12'h7ff);
      end else begin
        write_reg(svnp_pkg::REG_RADIUS, 12'($urandom));
        write_reg(svnp_pkg::REG_CENTER_X, 12'($urandom));
        write_reg(svnp_pkg::REG_CENTER_Y, 12'($urandom));
        write_reg(svnp_pkg::REG_CENTER_Z, 12'($urandom));
      end
      for (int i = 0; i < 200; i++) begin
        if ($urandom_range(0, 49) == 0) add_vertex(0, 0, 0);
        else add_vertex(rand_coord(), rand_coord(), rand_coord());
      end
      drain();
    end
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    #5ms;
    $display("Some tests failed");
    $finish;
  end
endmodule
